// ----- sv/irrigation_pump_decider_core_assert.svh -----
// Assertion macros shared by the irrigation pump decider modules.
// Depends on nothing; each module that checks itself includes this header.
`ifndef IRRIGATION_PUMP_DECIDER_CORE_ASSERT_SVH
`define IRRIGATION_PUMP_DECIDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define IPD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define IPD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ipd_pkg.sv -----
// Shared types, constants and the PID band function of the pump decider.
// Used by every module of the block; depends on nothing.
package ipd_pkg;

  // Default number of sensor slots averaged before a decision.
  localparam int SLOT_COUNT_DEF = 5;

  // Configuration port geometry and register indexes.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam logic [2:0] REG_WATER_ID  = 3'd0;
  localparam logic [2:0] REG_LEVEL_ACC = 3'd1;
  localparam logic [2:0] REG_VERY_LOW  = 3'd2;
  localparam logic [2:0] REG_LOW       = 3'd3;
  localparam logic [2:0] REG_TARGET    = 3'd4;

  // Register reset values.
  localparam logic [15:0] WATER_ID_RST  = 16'd0;
  localparam logic [7:0]  LEVEL_ACC_RST = 8'd80;
  localparam logic [7:0]  VERY_LOW_RST  = 8'd20;
  localparam logic [7:0]  LOW_RST       = 8'd40;
  localparam logic [7:0]  TARGET_RST    = 8'd50;

  // PID widths: error is 9 bits, the integral 16 bits, the control sum 18 bits.
  localparam int ERR_W = 9;
  localparam int INT_W = 16;
  localparam int CTL_W = 18;

  // Band edges of the control value table.
  localparam logic signed [CTL_W-1:0] EDGE_200 = CTL_W'(200);
  localparam logic signed [CTL_W-1:0] EDGE_150 = CTL_W'(150);
  localparam logic signed [CTL_W-1:0] EDGE_90  = CTL_W'(90);
  localparam logic signed [CTL_W-1:0] EDGE_30  = CTL_W'(30);
  localparam logic signed [CTL_W-1:0] EDGE_0   = CTL_W'(0);

  typedef struct packed {
    logic [15:0] water_sensor_id;
    logic [7:0]  level_accepted;
    logic [7:0]  thr_very_low;
    logic [7:0]  thr_low;
    logic [7:0]  pid_target;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PID_SUM,
    S_PID_CTL,
    S_SLOT,
    S_CHECK,
    S_ACCUM,
    S_DIV_MUL,
    S_DIV_FIX,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic pid_sum;
    logic pid_ctl;
    logic set_refill;
    logic set_pulse;
    logic slot_write;
    logic acc_clr;
    logic acc_step;
    logic div_mul;
    logic div_fix;
    logic clear_state;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic water;
    logic dry;
    logic last_full;
    logic acc_last;
    logic out_busy;
  } sts_t;

  // Maps the control value to a drive level; band edges themselves give zero.
  function automatic logic [1:0] band_level(input logic signed [CTL_W-1:0] c);
    logic [1:0] lvl;
    lvl = 2'd0;
    if (c > -EDGE_200 && c < -EDGE_150)     lvl = 2'd3;
    else if (c > -EDGE_150 && c < -EDGE_90) lvl = 2'd2;
    else if (c > -EDGE_90 && c < -EDGE_30)  lvl = 2'd2;
    else if (c > -EDGE_30 && c < EDGE_0)    lvl = 2'd1;
    else if (c > EDGE_0 && c < EDGE_30)     lvl = 2'd3;
    else if (c > EDGE_30 && c < EDGE_90)    lvl = 2'd2;
    else if (c > EDGE_90 && c < EDGE_150)   lvl = 2'd1;
    else if (c > EDGE_150 && c < EDGE_200)  lvl = 2'd1;
    return lvl;
  endfunction

endpackage

// ----- sv/ipd_regs.sv -----
// Configuration register file of the pump decider, behind an APB-style port.
// Depends on ipd_pkg for the register map, reset values and cfg_t.
module ipd_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ipd_pkg::ADDR_W-1:0] paddr,
  input  logic [ipd_pkg::DATA_W-1:0] pwdata,
  output logic [ipd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output ipd_pkg::cfg_t              cfg
);
  import ipd_pkg::*;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes; addresses past the last register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.water_sensor_id <= WATER_ID_RST;
      cfg.level_accepted  <= LEVEL_ACC_RST;
      cfg.thr_very_low    <= VERY_LOW_RST;
      cfg.thr_low         <= LOW_RST;
      cfg.pid_target      <= TARGET_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WATER_ID:  cfg.water_sensor_id <= pwdata[15:0];
        REG_LEVEL_ACC: cfg.level_accepted  <= pwdata[7:0];
        REG_VERY_LOW:  cfg.thr_very_low    <= pwdata[7:0];
        REG_LOW:       cfg.thr_low         <= pwdata[7:0];
        REG_TARGET:    cfg.pid_target      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux, zero extended to the bus width.
  always_comb begin
    unique case (reg_idx)
      REG_WATER_ID:  prdata = DATA_W'(cfg.water_sensor_id);
      REG_LEVEL_ACC: prdata = DATA_W'(cfg.level_accepted);
      REG_VERY_LOW:  prdata = DATA_W'(cfg.thr_very_low);
      REG_LOW:       prdata = DATA_W'(cfg.thr_low);
      REG_TARGET:    prdata = DATA_W'(cfg.pid_target);
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- sv/ipd_ctrl.sv -----
// Controller state machine of the pump decider: sequences one item at a time.
// Depends on ipd_pkg for state_t, cmd_t and sts_t, and on the assertion header.
`include "irrigation_pump_decider_core_assert.svh"

module ipd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ipd_pkg::sts_t sts,
  output ipd_pkg::cmd_t cmd
);
  import ipd_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_PID_SUM;
        end
      end
      S_PID_SUM: begin
        cmd.pid_sum = 1'b1;
        state_next  = S_PID_CTL;
      end
      S_PID_CTL: begin
        cmd.pid_ctl = 1'b1;
        state_next  = S_SLOT;
      end
      S_SLOT: begin
        if (sts.water) begin
          cmd.set_refill = 1'b1;
          state_next     = S_FINISH;
        end else if (sts.dry) begin
          cmd.set_pulse   = 1'b1;
          cmd.clear_state = 1'b1;
          state_next      = S_FINISH;
        end else begin
          cmd.slot_write = 1'b1;
          state_next     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.last_full) begin
          cmd.acc_clr = 1'b1;
          state_next  = S_ACCUM;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_ACCUM: begin
        cmd.acc_step = 1'b1;
        if (sts.acc_last) begin
          state_next = S_DIV_MUL;
        end
      end
      S_DIV_MUL: begin
        cmd.div_mul = 1'b1;
        state_next  = S_DIV_FIX;
      end
      S_DIV_FIX: begin
        cmd.div_fix     = 1'b1;
        cmd.clear_state = 1'b1;
        state_next      = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // New items are taken only between items; the output register decouples the result.
  assign in_stall = (state != S_IDLE);

  `IPD_ASSERT_IMP(a_load_free, clk, rst, cmd.out_load, !sts.out_busy, "result loaded over a waiting item")
  `IPD_ASSERT_NXT(a_accept_start, clk, rst, state == S_IDLE && in_valid, state == S_PID_SUM, "accepted item did not start the PID step")
  `IPD_ASSERT_NXT(a_accum_walk, clk, rst, state == S_ACCUM && !sts.acc_last, state == S_ACCUM, "slot sum left before the last slot")

endmodule

// ----- sv/ipd_dpath.sv -----
// Datapath of the pump decider: PID state, slot table, averaging and output register.
// Depends on ipd_pkg for cfg_t, cmd_t, sts_t and band_level, and on the assertion header.
`include "irrigation_pump_decider_core_assert.svh"

module ipd_dpath #(
  parameter int SLOT_COUNT = ipd_pkg::SLOT_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  ipd_pkg::cfg_t cfg,
  input  ipd_pkg::cmd_t cmd,
  output ipd_pkg::sts_t sts,
  input  logic [15:0]   sensor_id,
  input  logic [7:0]    reading,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    pump_seconds,
  output logic          refill_needed,
  output logic          average_valid,
  output logic [7:0]    average_value,
  output logic [1:0]    drive_level
);
  import ipd_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SUM_W = $clog2(SLOT_COUNT * 255 + 1);
  localparam int RCP_W = SUM_W + 1;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((1 << SUM_W) / SLOT_COUNT);
  localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  // Captured item.
  logic [15:0] id_r;
  logic [7:0]  rd_r;

  // PID state and intermediate values.
  logic signed [INT_W-1:0] error_sum;
  logic signed [ERR_W-1:0] previous_error;
  logic signed [ERR_W-1:0] err_r;
  logic signed [ERR_W-1:0] err;
  logic signed [INT_W:0]   sum_ext;
  logic signed [INT_W-1:0] sum_sat;
  logic signed [ERR_W:0]   err_diff;
  logic signed [CTL_W-1:0] ctl;
  logic [1:0]              level;

  // Slot table.
  logic [15:0] slot_ids      [SLOT_COUNT];
  logic [7:0]  slot_readings [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] match;
  logic [SLOT_COUNT-1:0] first_free;
  logic                  found;

  // Averaging.
  logic [IDX_W-1:0]       idx;
  logic [SUM_W-1:0]       acc;
  logic [SUM_W-1:0]       q0;
  logic [SUM_W+RCP_W-1:0] prod;
  logic [SUM_W-1:0]       q0_times_n;
  logic [SUM_W-1:0]       rem;
  logic [SUM_W-1:0]       quot;
  logic [7:0]             avg8;

  // Result under construction.
  logic [1:0] res_pump;
  logic       res_refill;
  logic       res_avg_valid;
  logic [7:0] res_avg;

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      id_r <= sensor_id;
      rd_r <= reading;
    end
  end

  // Error, saturated integral and control value.
  always_comb begin
    err      = ERR_W'($signed({1'b0, cfg.pid_target}) - $signed({1'b0, rd_r}));
    sum_ext  = (INT_W + 1)'(error_sum) + (INT_W + 1)'(err);
    if (sum_ext[INT_W] != sum_ext[INT_W-1]) begin
      sum_sat = sum_ext[INT_W] ? {1'b1, {(INT_W - 1){1'b0}}} : {1'b0, {(INT_W - 1){1'b1}}};
    end else begin
      sum_sat = sum_ext[INT_W-1:0];
    end
    err_diff = (ERR_W + 1)'(err_r) - (ERR_W + 1)'(previous_error);
    ctl      = (CTL_W'(err_r) <<< 1) + CTL_W'(error_sum) + (CTL_W'(err_diff) <<< 1);
  end

  // PID state registers; the integral takes the fresh error while the error is registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (cmd.clear_state) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (cmd.pid_sum) begin
      error_sum <= sum_sat;
    end else if (cmd.pid_ctl) begin
      previous_error <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      err_r <= '0;
    end else if (cmd.pid_sum) begin
      err_r <= err;
    end
  end

  // Band level of the control value, formed in the cycle after the integral update.
  always_ff @(posedge clk) begin
    if (cmd.pid_ctl) begin
      level <= band_level(ctl);
    end
  end

  // Slot matching and first free slot search.
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match[i] = (slot_ids[i] == id_r);
    end
  end

  assign found = |match;

  always_comb begin
    logic taken;
    taken = found;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      first_free[i] = !taken && (slot_ids[i] == 16'd0);
      taken         = taken || first_free[i];
    end
  end

  // Slot table updates and clearing.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_state) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_ids[i]      <= '0;
        slot_readings[i] <= '0;
      end
    end else if (cmd.slot_write) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (match[i]) begin
          slot_readings[i] <= rd_r;
        end else if (first_free[i]) begin
          slot_ids[i]      <= id_r;
          slot_readings[i] <= rd_r;
        end
      end
    end
  end

  // Sum of slot readings, one slot a cycle.
  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc <= '0;
      idx <= '0;
    end else if (cmd.acc_step) begin
      acc <= acc + SUM_W'(slot_readings[idx]);
      idx <= idx + IDX_W'(1);
    end
  end

  // Division by the slot count: reciprocal multiply, then one correction step.
  assign prod = acc * RECIP;

  always_ff @(posedge clk) begin
    if (cmd.div_mul) begin
      q0 <= prod[2*SUM_W-1:SUM_W];
    end
  end

  always_comb begin
    q0_times_n = SUM_W'(q0 * DIVISOR);
    rem        = acc - q0_times_n;
    quot       = (rem >= DIVISOR) ? q0 + SUM_W'(1) : q0;
    avg8       = quot[7:0];
  end

  // Result fields of the current item.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      res_pump      <= 2'd0;
      res_refill    <= 1'b0;
      res_avg_valid <= 1'b0;
      res_avg       <= 8'd0;
    end else if (cmd.set_refill) begin
      res_refill <= (rd_r < cfg.level_accepted);
    end else if (cmd.set_pulse) begin
      res_pump <= (level == 2'd0) ? 2'd1 : level;
    end else if (cmd.div_fix) begin
      res_avg_valid <= 1'b1;
      res_avg       <= avg8;
      res_pump      <= (avg8 > cfg.thr_very_low && avg8 < cfg.thr_low) ? 2'd1 : 2'd0;
    end
  end

  // Output register; holds while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pump_seconds  <= res_pump;
      refill_needed <= res_refill;
      average_valid <= res_avg_valid;
      average_value <= res_avg;
      drive_level   <= level;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.water     = (id_r == cfg.water_sensor_id);
    sts.dry       = (rd_r < cfg.thr_very_low);
    sts.last_full = (slot_ids[SLOT_COUNT-1] != 16'd0);
    sts.acc_last  = (idx == LAST_IDX);
    sts.out_busy  = out_valid && out_stall;
  end

  `IPD_ASSERT_NXT(a_clear_empties, clk, rst, cmd.clear_state, slot_ids[SLOT_COUNT-1] == 16'd0 && error_sum == '0, "state not cleared")
  `IPD_ASSERT_IMP(a_avg_pulse, clk, rst, out_valid && average_valid, pump_seconds == 2'd0 || pump_seconds == 2'd1, "average item with long pulse")
  `IPD_ASSERT_NXT(a_hold_stalled, clk, rst, out_valid && out_stall, out_valid && $stable(average_value) && $stable(pump_seconds), "stalled result changed")

endmodule

// ----- sv/irrigation_pump_decider_core.sv -----
// Top level of the irrigation pump decider: registers, controller and datapath.
// Depends on ipd_pkg, ipd_regs, ipd_ctrl and ipd_dpath.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  sensor_id, reading
//   result   out        out_valid / out_stall pump_seconds, refill_needed,
//                                            average_valid, average_value, drive_level
//   config   in/out     psel, penable, pready paddr, pwdata, prdata (5 registers)
//
// An item passes the PID sum and control steps, then the slot step; the water sensor
// and very-dry paths go on to the finish, a plain slot update passes the check first,
// and a full table is averaged one slot per cycle, then divided by the slot count.
// One item is worked at a time; the next is accepted while the result waits in its
// output register. Reset is synchronous and clears the slots and PID state at once.
// A stalled result holds; the controller waits in its last state if the register is full.
module irrigation_pump_decider_core #(
  parameter int SLOT_COUNT = ipd_pkg::SLOT_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [15:0]                sensor_id,
  input  logic [7:0]                 reading,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 pump_seconds,
  output logic                       refill_needed,
  output logic                       average_valid,
  output logic [7:0]                 average_value,
  output logic [1:0]                 drive_level,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ipd_pkg::ADDR_W-1:0] paddr,
  input  logic [ipd_pkg::DATA_W-1:0] pwdata,
  output logic [ipd_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import ipd_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  ipd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ipd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ipd_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .sensor_id     (sensor_id),
    .reading       (reading),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pump_seconds  (pump_seconds),
    .refill_needed (refill_needed),
    .average_valid (average_valid),
    .average_value (average_value),
    .drive_level   (drive_level)
  );

endmodule
